FILE: rtl/ibus_frame_receiver_unit_macros.svh
// Assertion helpers for the checker file.
`ifndef IBUS_FRAME_RECEIVER_UNIT_MACROS_SVH
`define IBUS_FRAME_RECEIVER_UNIT_MACROS_SVH

// Concurrent check, muted while reset is held.
`define IFR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("%m: check failed");

// Concurrent check that also holds across reset.
`define IFR_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("%m: check failed");

`endif

FILE: rtl/ifr_pkg.sv
`default_nettype none

package ifr_pkg;

    // Frame geometry
    localparam int NUM_CHANNELS   = 14;
    localparam int FRAME_OVERHEAD = 3;
    localparam int STORE_BYTES    = 32;
    localparam int STORE_AW       = $clog2(STORE_BYTES);
    localparam int CHAN_W         = 4;
    localparam logic [CHAN_W-1:0] LAST_INDEX = CHAN_W'(NUM_CHANNELS - 1);

    // Largest length byte honoured, whatever max_length holds
    localparam logic [5:0] LENGTH_CAP = 6'd32;

    // Command queue between parser and emitter
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_GAP_TICKS    = 2'd0,
        CFG_MAX_LENGTH   = 2'd1,
        CFG_COMMAND_CODE = 2'd2
    } t_cfg_index;

    // Configuration register set
    typedef struct packed {
        logic [15:0] gap_ticks;
        logic [5:0]  max_length;
        logic [7:0]  command_code;
    } t_cfg;

    // One request for the back end: a store write or a channel dump
    typedef struct packed {
        logic                is_emit;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } t_cmd;

    // Queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

FILE: rtl/ifr_front.sv
`default_nettype none

module ifr_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ifr_pkg::t_cfg i_cfg,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic          i_operation,
    input  wire logic [7:0]    i_data_byte,
    input  wire ifr_pkg::t_q_status i_q_status,
    output logic               o_push,
    output ifr_pkg::t_cmd      o_push_cmd
);
    import ifr_pkg::*;

    typedef enum logic [1:0] {
        PH_DISCARD  = 2'd0,
        PH_DATA     = 2'd1,
        PH_SUM_LOW  = 2'd2,
        PH_SUM_HIGH = 2'd3
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [15:0]         r_idle, n_idle;
    logic [STORE_AW-1:0] r_pos, n_pos;
    logic [STORE_AW-1:0] r_plen, n_plen;
    logic [15:0]         r_sum, n_sum;
    logic [7:0]          r_low, n_low;
    logic [7:0]          r_cmd_byte, n_cmd_byte;

    logic                w_accept;
    logic [5:0]          w_limit;
    logic [STORE_AW-1:0] w_pos_inc;

    // Hold off new requests while the queue has no room
    assign o_in_ready = !i_q_status.full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_limit    = (i_cfg.max_length > LENGTH_CAP) ? LENGTH_CAP : i_cfg.max_length;
    assign w_pos_inc  = r_pos + STORE_AW'(1);

    // Byte classification and checksum
    always_comb begin
        n_phase    = r_phase;
        n_idle     = r_idle;
        n_pos      = r_pos;
        n_plen     = r_plen;
        n_sum      = r_sum;
        n_low      = r_low;
        n_cmd_byte = r_cmd_byte;
        o_push     = 1'b0;
        o_push_cmd = '{is_emit: 1'b0, addr: r_pos, data: i_data_byte};
        if (w_accept) begin
            if (i_operation) begin
                // tick: saturating idle count
                if (r_idle != 16'hFFFF) begin
                    n_idle = r_idle + 16'd1;
                end
            end else begin
                n_idle = 16'd0;
                if (r_idle >= i_cfg.gap_ticks) begin
                    // sync point: this byte is the frame length
                    if (i_data_byte > 8'(FRAME_OVERHEAD) && i_data_byte <= {2'b00, w_limit}) begin
                        n_pos   = '0;
                        n_plen  = STORE_AW'(i_data_byte - 8'(FRAME_OVERHEAD));
                        n_sum   = 16'hFFFF - {8'h00, i_data_byte};
                        n_phase = PH_DATA;
                    end else begin
                        n_phase = PH_DISCARD;
                    end
                end else begin
                    case (r_phase)
                        PH_DATA: begin
                            o_push = 1'b1;
                            if (r_pos == '0) begin
                                n_cmd_byte = i_data_byte;
                            end
                            n_pos = w_pos_inc;
                            n_sum = r_sum - {8'h00, i_data_byte};
                            if (w_pos_inc == r_plen) begin
                                n_phase = PH_SUM_LOW;
                            end
                        end
                        PH_SUM_LOW: begin
                            n_low   = i_data_byte;
                            n_phase = PH_SUM_HIGH;
                        end
                        PH_SUM_HIGH: begin
                            if (r_sum == {i_data_byte, r_low} &&
                                r_cmd_byte == i_cfg.command_code) begin
                                o_push             = 1'b1;
                                o_push_cmd.is_emit = 1'b1;
                            end
                            n_phase = PH_DISCARD;
                        end
                        default: begin
                            n_phase = PH_DISCARD;
                        end
                    endcase
                end
            end
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        r_low      <= n_low;
        r_cmd_byte <= n_cmd_byte;
        if (!i_rst_n) begin
            r_phase <= PH_DISCARD;
            r_idle  <= '0;
            r_pos   <= '0;
            r_plen  <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_idle  <= n_idle;
            r_pos   <= n_pos;
            r_plen  <= n_plen;
            r_sum   <= n_sum;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ifr_cmd_queue.sv
`default_nettype none

module ifr_cmd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ifr_pkg::t_cmd i_push_cmd,
    input  wire logic          i_pop,
    output ifr_pkg::t_cmd      o_pop_cmd,
    output ifr_pkg::t_q_status o_status
);
    import ifr_pkg::*;

    t_cmd                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_status.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_pop_cmd      = r_slot[r_rd_ptr];

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QUEUE_AW+1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ifr_back.sv
`default_nettype none

module ifr_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ifr_pkg::t_q_status i_q_status,
    input  wire ifr_pkg::t_cmd i_q_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [3:0]         o_channel_index,
    output logic [15:0]        o_channel_value,
    output logic               o_last_channel
);
    import ifr_pkg::*;

    typedef enum logic {
        BS_IDLE = 1'b0,
        BS_EMIT = 1'b1
    } t_bstate;

    // Frame byte store with per-entry valid bits (unwritten reads as zero)
    logic [7:0]             r_mem [STORE_BYTES];
    logic [STORE_BYTES-1:0] r_vld;

    t_bstate             r_state;
    logic [CHAN_W-1:0]   r_k;
    logic                r_rd_valid;
    logic [CHAN_W-1:0]   r_rd_k;
    logic                r_rd_lo_ok, r_rd_hi_ok;
    logic [7:0]          r_rd_lo, r_rd_hi;
    logic                r_out_valid;
    logic [CHAN_W-1:0]   r_out_idx;
    logic [15:0]         r_out_value;
    logic                r_out_last;

    logic                w_out_free, w_rd_free, w_issue, w_write;
    logic [STORE_AW-1:0] w_addr_lo, w_addr_hi;

    assign o_pop      = (r_state == BS_IDLE) && !i_q_status.empty;
    assign w_write    = o_pop && !i_q_cmd.is_emit;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_rd_free  = !r_rd_valid || w_out_free;
    assign w_issue    = (r_state == BS_EMIT) && w_rd_free;
    assign w_addr_lo  = STORE_AW'({1'b0, r_k, 1'b1});
    assign w_addr_hi  = w_addr_lo + STORE_AW'(1);

    assign o_out_valid     = r_out_valid;
    assign o_channel_index = r_out_idx;
    assign o_channel_value = r_out_value;
    assign o_last_channel  = r_out_last;

    // Store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_mem[i_q_cmd.addr] <= i_q_cmd.data;
        end
        if (w_issue) begin
            r_rd_lo <= r_mem[w_addr_lo];
            r_rd_hi <= r_mem[w_addr_hi];
        end
    end

    // Sequencer, read stage and output register
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_k     <= r_k;
            r_rd_lo_ok <= r_vld[w_addr_lo];
            r_rd_hi_ok <= r_vld[w_addr_hi];
        end
        if (w_out_free && r_rd_valid) begin
            r_out_idx   <= r_rd_k;
            r_out_value <= {r_rd_hi_ok ? r_rd_hi : 8'h00, r_rd_lo_ok ? r_rd_lo : 8'h00};
            r_out_last  <= (r_rd_k == LAST_INDEX);
        end
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_k         <= '0;
            r_vld       <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_write) begin
                r_vld[i_q_cmd.addr] <= 1'b1;
            end
            case (r_state)
                BS_IDLE: begin
                    if (o_pop && i_q_cmd.is_emit) begin
                        r_state <= BS_EMIT;
                        r_k     <= '0;
                    end
                end
                BS_EMIT: begin
                    if (w_issue) begin
                        r_k <= r_k + CHAN_W'(1);
                        if (r_k == LAST_INDEX) begin
                            r_state <= BS_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= BS_IDLE;
                end
            endcase
            if (w_rd_free) begin
                r_rd_valid <= w_issue;
            end
            if (w_out_free) begin
                r_out_valid <= r_rd_valid;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ibus_frame_receiver_unit.sv
`default_nettype none

// Serial servo frame receiver. Each request is either a received byte or a
// one millisecond tick; ticks and bytes are taken one per clock while the
// four-entry command queue between the parser and the channel emitter has
// room. A byte after at least gap_ticks idle ticks is the frame length, the
// payload is stored and checksummed, and a closing checksum that matches, with
// a matching command byte, yields 14 channel results, the last one flagged.
// The emitter drains one queued store write per cycle while it is not
// streaming, and streams the 14 channels at one per cycle when the output is
// not stalled, paced by its single registered read of the frame store. Reset
// is synchronous and needs no clearing pass; store entries never written read
// as zero. Configuration writes are always accepted; index 3 is ignored.
module ibus_frame_receiver_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_operation,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [3:0]       o_channel_index,
    output logic [15:0]      o_channel_value,
    output logic             o_last_channel
);
    import ifr_pkg::*;

    t_cfg      r_cfg;
    logic      w_push, w_pop;
    t_cmd      w_push_cmd, w_pop_cmd;
    t_q_status w_q_status;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gap_ticks    <= 16'd3;
            r_cfg.max_length   <= 6'd32;
            r_cfg.command_code <= 8'd64;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GAP_TICKS:    r_cfg.gap_ticks    <= i_cfg_data;
                CFG_MAX_LENGTH:   r_cfg.max_length   <= i_cfg_data[5:0];
                CFG_COMMAND_CODE: r_cfg.command_code <= i_cfg_data[7:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    // Parser
    ifr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_data_byte (i_data_byte),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_push_cmd  (w_push_cmd)
    );

    // Request queue
    ifr_cmd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_push_cmd),
        .i_pop      (w_pop),
        .o_pop_cmd  (w_pop_cmd),
        .o_status   (w_q_status)
    );

    // Store and channel emitter
    ifr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_status      (w_q_status),
        .i_q_cmd         (w_pop_cmd),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_last_channel  (o_last_channel)
    );

endmodule

`default_nettype wire

FILE: rtl/ifr_checker.sv
`default_nettype none

`include "ibus_frame_receiver_unit_macros.svh"

module ifr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [3:0]  o_channel_index,
    input wire logic [15:0] o_channel_value,
    input wire logic        o_last_channel
);
    import ifr_pkg::*;

    // A stalled result holds
    `IFR_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_channel_value) && $stable(o_channel_index) && $stable(o_last_channel))

    // Last flag marks exactly the final channel
    `IFR_ASSERT(a_last_flag, o_out_valid |-> (o_last_channel == (o_channel_index == LAST_INDEX)))

    // Channels of a frame leave in order
    `IFR_ASSERT(a_index_step, o_out_valid && i_out_ready && !o_last_channel |=> !o_out_valid || (o_channel_index == $past(o_channel_index) + 4'd1))

    // Nothing is offered straight after reset
    `IFR_ASSERT_RST(a_reset_quiet, !i_rst_n |=> !o_out_valid)

endmodule

bind ibus_frame_receiver_unit ifr_checker u_ifr_checker (.*);

`default_nettype wire

FILE: sim/ibus_frame_receiver_unit_tb.sv
`timescale 1ns / 100ps

module ibus_frame_receiver_unit_tb;

    import ifr_pkg::*;

    localparam logic       OP_BYTE       = 1'b0;
    localparam logic       OP_TICK       = 1'b1;
    localparam logic [1:0] CFG_SPARE     = 2'd3;
    localparam int         IDLE_PCT      = 8;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         RANDOM_ITEMS  = 120;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         MAX_REPORTS   = 50;
    localparam longint     TIMEOUT_NS    = 64'd20_000_000;

    typedef enum logic [1:0] {
        HUNT_SYNC,
        TAKE_PAYLOAD,
        TAKE_SUM_LO,
        TAKE_SUM_HI
    } parse_phase_t;

    typedef enum logic [1:0] {
        FRAME_GOOD,
        FRAME_BAD_SUM,
        FRAME_CUT
    } frame_flaw_t;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } serial_req_t;

    typedef struct packed {
        logic [3:0]  index;
        logic [15:0] value;
        logic        last;
    } channel_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_operation;
    logic [7:0]  i_data_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [3:0]  o_channel_index;
    logic [15:0] o_channel_value;
    logic        o_last_channel;

    // Requests waiting for the serial side, channels waiting for the output
    serial_req_t serial_backlog [$];
    channel_t    due_channels [$];
    int          items_queued   = 0;
    int          mismatch_count = 0;
    bit          no_idle        = 1'b0;
    int          hold_request   = 0;

    // Receiver image: registers and parse state
    logic [15:0]  gap_setting;
    logic [5:0]   max_length_setting;
    logic [7:0]   command_setting;
    parse_phase_t phase;
    logic [15:0]  idle_ticks;
    logic [4:0]   byte_pos;
    logic [4:0]   payload_len;
    logic [15:0]  sum_left;
    logic [7:0]   sum_lo;
    logic [7:0]   frame_bytes [STORE_BYTES];

    ibus_frame_receiver_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_last_channel  (o_last_channel)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    // Length bytes above the cap behave as the cap
    function automatic int length_limit();
        if (max_length_setting > LENGTH_CAP) return int'(LENGTH_CAP);
        return int'(max_length_setting);
    endfunction

    // Step the receiver image by one accepted request; queue any channels it yields
    function automatic void decode_request(input serial_req_t req);
        logic [7:0] b;
        b = req.data;
        if (req.op == OP_TICK) begin
            if (idle_ticks != 16'hFFFF) idle_ticks++;
            return;
        end
        // byte after a long enough gap is a length byte
        if (idle_ticks >= gap_setting) begin
            idle_ticks = '0;
            if (b > FRAME_OVERHEAD && b <= length_limit()) begin
                byte_pos    = '0;
                payload_len = 5'(b - FRAME_OVERHEAD);
                sum_left    = 16'hFFFF - 16'(b);
                phase       = TAKE_PAYLOAD;
            end else begin
                phase = HUNT_SYNC;
            end
            return;
        end
        idle_ticks = '0;
        case (phase)
            TAKE_PAYLOAD: begin
                frame_bytes[byte_pos] = b;
                byte_pos++;
                sum_left -= 16'(b);
                if (byte_pos == payload_len) phase = TAKE_SUM_LO;
            end
            TAKE_SUM_LO: begin
                sum_lo = b;
                phase  = TAKE_SUM_HI;
            end
            TAKE_SUM_HI: begin
                if (sum_left == {b, sum_lo} && frame_bytes[0] == command_setting) begin
                    for (int k = 0; k < NUM_CHANNELS; k++) begin
                        due_channels.push_back('{index: 4'(k),
                                                 value: {frame_bytes[2 + 2 * k],
                                                         frame_bytes[1 + 2 * k]},
                                                 last:  (k == NUM_CHANNELS - 1)});
                    end
                end
                phase = HUNT_SYNC;
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("%0t ns  mismatch: %s", $time, what);
    endtask

    // Queue one request for the serial side
    task automatic send_request(input logic op, input logic [7:0] data);
        serial_backlog.push_back('{op: op, data: data});
        items_queued++;
    endtask

    task automatic send_ticks(input int count);
        for (int i = 0; i < count; i++) send_request(OP_TICK, 8'($urandom));
    endtask

    function automatic int lead_gap();
        return int'(gap_setting) + $urandom_range(0, 2);
    endfunction

    // Gap, length byte, payload with command byte first, checksum low then high
    task automatic send_frame(input int lead, input int len, input logic [7:0] cmd_byte,
                              input frame_flaw_t flaw);
        logic [15:0] csum;
        logic [7:0]  body [$];
        int          count;
        csum = 16'hFFFF - 16'(len);
        for (int i = 0; i < len - FRAME_OVERHEAD; i++) begin
            body.push_back((i == 0) ? cmd_byte : 8'($urandom));
            csum -= 16'(body[i]);
        end
        if (flaw == FRAME_BAD_SUM) csum ^= 16'($urandom_range(1, 16'hFFFF));
        body.push_back(csum[7:0]);
        body.push_back(csum[15:8]);
        count = (flaw == FRAME_CUT) ? $urandom_range(0, body.size() - 1) : body.size();
        send_ticks(lead);
        send_request(OP_BYTE, 8'(len));
        for (int i = 0; i < count; i++) begin
            // short pause inside the frame, below the gap
            if (gap_setting >= 2 && $urandom_range(9) == 0)
                send_ticks($urandom_range(1, (gap_setting > 4) ? 3 : gap_setting - 1));
            send_request(OP_BYTE, body[i]);
        end
    endtask

    // Wait until every request is taken and every channel has come, then let it settle
    task automatic wait_idle();
        while (serial_backlog.size() != 0 || due_channels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_GAP_TICKS:    gap_setting        = value;
            CFG_MAX_LENGTH:   max_length_setting = value[5:0];
            CFG_COMMAND_CODE: command_setting    = value[7:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    // Serial side driver: presents the oldest queued request, idles at random
    initial begin : request_driver
        i_in_valid  <= 1'b0;
        i_operation <= OP_BYTE;
        i_data_byte <= '0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (i_in_valid && o_in_ready) decode_request(serial_backlog.pop_front());
            if (!i_in_valid || o_in_ready) begin
                if (serial_backlog.size() != 0 &&
                    (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                    i_in_valid  <= 1'b1;
                    i_operation <= serial_backlog[0].op;
                    i_data_byte <= serial_backlog[0].data;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: random stalls, or a counted hold-off when asked
    initial begin : channel_sink
        int hold_left;
        hold_left = 0;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Compare each accepted channel with the oldest one due
    initial begin : result_checker
        channel_t want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (due_channels.size() == 0) begin
                    report_mismatch($sformatf("channel %0d value %h with nothing due",
                                              o_channel_index, o_channel_value));
                end else begin
                    want = due_channels.pop_front();
                    if (o_channel_index !== want.index)
                        report_mismatch($sformatf("channel_index %0d, want %0d",
                                                  o_channel_index, want.index));
                    if (o_channel_value !== want.value)
                        report_mismatch($sformatf("channel_value %h, want %h (channel %0d)",
                                                  o_channel_value, want.value, want.index));
                    if (o_last_channel !== want.last)
                        report_mismatch($sformatf("last_channel %b, want %b (channel %0d)",
                                                  o_last_channel, want.last, want.index));
                end
            end
        end
    end

    // Bytes without a gap after reset, and the shortest frame over an empty store
    task automatic test_reset_state();
        send_request(OP_BYTE, 8'hFF);
        send_ticks(2);
        send_request(OP_BYTE, 8'd4);
        send_frame(lead_gap(), 4, command_setting, FRAME_GOOD);
    endtask

    // Length bytes too short, too long, and the full frame
    task automatic test_length_limits();
        send_ticks(lead_gap());
        send_request(OP_BYTE, 8'd0);
        send_ticks(lead_gap());
        send_request(OP_BYTE, 8'd3);
        send_ticks(lead_gap());
        send_request(OP_BYTE, 8'd33);
        send_ticks(lead_gap());
        send_request(OP_BYTE, 8'hFF);
        send_frame(lead_gap(), 32, command_setting, FRAME_GOOD);
    endtask

    task automatic test_frame_faults();
        send_frame(lead_gap(), 6, command_setting, FRAME_BAD_SUM);
        send_frame(lead_gap(), 6, command_setting ^ 8'h01, FRAME_GOOD);
        // gap in mid frame drops it and the next byte is a new length
        send_ticks(lead_gap());
        send_request(OP_BYTE, 8'd10);
        repeat (3) send_request(OP_BYTE, 8'($urandom));
        // short frame: upper channels come from stale store bytes
        send_frame(lead_gap(), 5, command_setting, FRAME_GOOD);
    endtask

    task automatic test_config_extremes();
        // limit above the cap acts as the cap
        write_cfg(CFG_MAX_LENGTH, {10'h3FF, 6'd63});
        send_frame(lead_gap(), 32, command_setting, FRAME_GOOD);
        // smallest limit: length 5 dropped, 4 taken
        write_cfg(CFG_MAX_LENGTH, 16'd4);
        send_frame(lead_gap(), 5, command_setting, FRAME_GOOD);
        send_frame(lead_gap(), 4, command_setting, FRAME_GOOD);
        write_cfg(CFG_MAX_LENGTH, 16'd32);
        // command code extremes
        write_cfg(CFG_COMMAND_CODE, 16'd0);
        send_frame(lead_gap(), 6, 8'h00, FRAME_GOOD);
        write_cfg(CFG_COMMAND_CODE, 16'hFFFF);
        send_frame(lead_gap(), 6, 8'hFF, FRAME_GOOD);
        // unused index must leave the registers alone
        write_cfg(CFG_SPARE, 16'($urandom));
        send_frame(lead_gap(), 6, 8'hFF, FRAME_GOOD);
        // zero gap: every byte is a length byte
        write_cfg(CFG_GAP_TICKS, 16'd0);
        repeat (10) send_request(OP_BYTE, 8'($urandom_range(0, 40)));
        send_frame(0, 5, 8'hFF, FRAME_GOOD);
        // wide gap: a shorter pause does not resync, a long enough one does
        write_cfg(CFG_GAP_TICKS, 16'd20);
        send_frame(10, 8, 8'hFF, FRAME_GOOD);
        send_frame(lead_gap(), 8, 8'hFF, FRAME_GOOD);
        write_cfg(CFG_GAP_TICKS, 16'd3);
        write_cfg(CFG_COMMAND_CODE, 16'd64);
    endtask

    // Output held off while frames keep coming, then a pause until all is out
    task automatic test_backpressure();
        no_idle      = 1'b1;
        hold_request = HOLD_CYCLES;
        repeat (6) send_frame(lead_gap(), 8, command_setting, FRAME_GOOD);
        wait_idle();
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        int base;
        int pick;
        for (int s = 0; s < 4; s++) begin
            case (s)
                0: begin
                    write_cfg(CFG_GAP_TICKS, 16'd3);
                    write_cfg(CFG_MAX_LENGTH, 16'd32);
                    write_cfg(CFG_COMMAND_CODE, 16'd64);
                end
                1: begin
                    write_cfg(CFG_GAP_TICKS, 16'd1);
                    write_cfg(CFG_MAX_LENGTH, {10'($urandom), 6'd63});
                    write_cfg(CFG_COMMAND_CODE, {8'($urandom), 8'd0});
                end
                2: begin
                    write_cfg(CFG_GAP_TICKS, 16'd2);
                    write_cfg(CFG_MAX_LENGTH, {10'($urandom), 6'($urandom_range(4, 31))});
                    write_cfg(CFG_COMMAND_CODE, 16'($urandom));
                end
                default: begin
                    write_cfg(CFG_GAP_TICKS, 16'($urandom_range(3, 5)));
                    write_cfg(CFG_MAX_LENGTH, 16'd32);
                    write_cfg(CFG_COMMAND_CODE, 16'd255);
                end
            endcase
            base = items_queued;
            while (items_queued - base < RANDOM_ITEMS / 4) begin
                pick = $urandom_range(99);
                if (pick < 70)
                    send_frame(lead_gap(), $urandom_range(4, length_limit()),
                               command_setting, FRAME_GOOD);
                else if (pick < 78)
                    send_frame(lead_gap(), $urandom_range(4, length_limit()),
                               command_setting, FRAME_BAD_SUM);
                else if (pick < 84)
                    send_frame(lead_gap(), $urandom_range(4, length_limit()),
                               command_setting ^ 8'($urandom_range(1, 255)), FRAME_GOOD);
                else if (pick < 90)
                    send_frame(lead_gap(), $urandom_range(4, length_limit()),
                               command_setting, FRAME_CUT);
                else
                    repeat ($urandom_range(1, 8))
                        send_request(1'($urandom_range(1)), 8'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_GAP_TICKS;
        i_cfg_data  <= '0;
        // image of the reset state
        gap_setting        = 16'd3;
        max_length_setting = 6'd32;
        command_setting    = 8'd64;
        phase              = HUNT_SYNC;
        idle_ticks         = '0;
        byte_pos           = '0;
        payload_len        = '0;
        sum_left           = '0;
        sum_lo             = '0;
        for (int i = 0; i < STORE_BYTES; i++) frame_bytes[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_length_limits();
        test_frame_faults();
        test_config_extremes();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
